FILE: hw/rtl/sfss_pkg.sv
`default_nettype none

package sfss_pkg;

  // flag bits that decide whether a record is dropped
  localparam logic [31:0] DROP_BIT  = 32'h2000_0000;
  localparam logic [31:0] SOLID_BIT = 32'h0000_0001;

  // one stored surface record
  typedef struct packed {
    logic [31:0] texture;
    logic [31:0] vtx_base;
    logic [31:0] idx_base;
    logic [31:0] idx_total;
  } rec_t;

  // what the chain does in a cycle
  typedef struct packed {
    logic insert;
    logic drain;
  } chain_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/surface_filter_stable_sort_top.sv
`default_nettype none

// Surface record filter and stable sort. Records arrive one beat per cycle;
// a record whose flags have bit 29 set and bit 0 clear is dropped, every
// other one is slotted straight into a row of MAX_SURFACES cells that keeps
// the held records in ascending texture order (equal textures stay in
// arrival order). After the beat marked in_last the input stalls while the
// row shifts its contents out through cell 0, one result per cycle while
// the output is not stalled, into an output register: a run with n kept
// records gives n results (one result marked out_empty with zero fields
// when nothing was kept), and the next run's first beat is taken the cycle
// after the final result is loaded, even if that result is still stalled.
// Kept records past capacity are lost and out_overflow is set on every
// result of that run. No clearing pass is needed after reset.

module surface_filter_stable_sort_top
  import sfss_pkg::*;
#(
  parameter int MAX_SURFACES = 64
) (
  input  wire         clk,
  input  wire         rst,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_flags,
  input  wire  [31:0] in_index_offset,
  input  wire  [31:0] in_index_count,
  input  wire  [31:0] in_vertex_offset,
  input  wire  [31:0] in_texture,
  input  wire         in_last,
  // output channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_index_offset,
  output logic [31:0] out_index_count,
  output logic [31:0] out_vertex_offset,
  output logic [31:0] out_texture,
  output logic        out_last,
  output logic        out_empty,
  output logic        out_overflow
);

  localparam int CW = $clog2(MAX_SURFACES + 1);

  typedef enum logic {S_FILL, S_DRAIN} state_t;

  state_t        state;
  logic [CW-1:0] count;     // records held in the row
  logic          overflow;  // a kept record found the row full this run

  chain_ctl_t ctl;
  rec_t       new_rec;
  rec_t       head;

  logic in_beat;
  logic keep;
  logic room;
  logic out_free;

  // input is held off only while the row is being emptied
  assign in_stall = (state == S_DRAIN);
  assign in_beat  = in_valid && !in_stall;

  assign keep = !(((in_flags & DROP_BIT) != '0) && ((in_flags & SOLID_BIT) == '0));
  assign room = (count < CW'(MAX_SURFACES));

  // the output register can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  assign new_rec.texture   = in_texture;
  assign new_rec.vtx_base  = in_vertex_offset;
  assign new_rec.idx_base  = in_index_offset;
  assign new_rec.idx_total = in_index_count;

  assign ctl.insert = in_beat && keep && room;
  assign ctl.drain  = (state == S_DRAIN) && out_free && (count != '0);

  sfss_chain #(
    .MAX_SURFACES (MAX_SURFACES),
    .CW           (CW)
  ) u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .count   (count),
    .new_rec (new_rec),
    .head    (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result taken downstream
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          if (in_beat) begin
            if (keep && room) begin
              count <= count + CW'(1);
            end else if (keep) begin
              overflow <= 1'b1;
            end
            if (in_last) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_overflow <= overflow;
            if (count == '0) begin
              // nothing kept: single empty marker
              out_index_offset  <= '0;
              out_index_count   <= '0;
              out_vertex_offset <= '0;
              out_texture       <= '0;
              out_last          <= 1'b1;
              out_empty         <= 1'b1;
              state             <= S_FILL;
              overflow          <= 1'b0;
            end else begin
              out_index_offset  <= head.idx_base;
              out_index_count   <= head.idx_total;
              out_vertex_offset <= head.vtx_base;
              out_texture       <= head.texture;
              out_last          <= (count == CW'(1));
              out_empty         <= 1'b0;
              count             <= count - CW'(1);
              if (count == CW'(1)) begin
                state    <= S_FILL;
                overflow <= 1'b0;
              end
            end
          end
        end
        default: begin
          state <= S_FILL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfss_cell.sv
`default_nettype none

module sfss_cell
  import sfss_pkg::*;
(
  input  wire             clk,
  input  wire chain_ctl_t ctl,
  input  wire             occ,
  input  wire rec_t       new_rec,
  input  wire rec_t       prev_rec,
  input  wire             prev_holds,
  input  wire rec_t       next_rec,
  output rec_t            rec,
  output logic            holds
);

  // an occupied cell keeping a key not above the new one stays put (stable order)
  assign holds = occ && (rec.texture <= new_rec.texture);

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      rec <= next_rec;
    end else if (ctl.insert && !holds) begin
      rec <= prev_holds ? new_rec : prev_rec;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfss_chain.sv
`default_nettype none

module sfss_chain
  import sfss_pkg::*;
#(
  parameter int MAX_SURFACES = 64,
  parameter int CW = $clog2(MAX_SURFACES + 1)
) (
  input  wire             clk,
  input  wire chain_ctl_t ctl,
  input  wire  [CW-1:0]   count,
  input  wire rec_t       new_rec,
  output rec_t            head
);

  rec_t recs  [MAX_SURFACES];
  logic holds [MAX_SURFACES];

  for (genvar i = 0; i < MAX_SURFACES; i++) begin : g_cell
    rec_t prev_rec;
    rec_t next_rec;
    logic prev_holds;
    logic occ;

    assign occ = (count > CW'(i));

    if (i == 0) begin : g_first
      assign prev_rec   = new_rec;
      assign prev_holds = 1'b1;
    end else begin : g_mid
      assign prev_rec   = recs[i-1];
      assign prev_holds = holds[i-1];
    end

    if (i == MAX_SURFACES - 1) begin : g_tail
      assign next_rec = recs[i];
    end else begin : g_body
      assign next_rec = recs[i+1];
    end

    sfss_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .new_rec    (new_rec),
      .prev_rec   (prev_rec),
      .prev_holds (prev_holds),
      .next_rec   (next_rec),
      .rec        (recs[i]),
      .holds      (holds[i])
    );
  end

  assign head = recs[0];

endmodule

`default_nettype wire

FILE: hw/rtl/sfss_checker.sv
`default_nettype none

module sfss_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        in_last,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_index_offset,
  input wire [31:0] out_index_count,
  input wire [31:0] out_vertex_offset,
  input wire [31:0] out_texture,
  input wire        out_last,
  input wire        out_empty,
  input wire        out_overflow
);

  // an empty marker closes its run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> out_last)
    else $error("empty result without last");

  // an empty marker carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_index_offset == '0 && out_index_count == '0 &&
                                  out_vertex_offset == '0 && out_texture == '0))
    else $error("empty result with nonzero fields");

  // the final beat of a set holds the input off while results drain
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("input not stalled after last beat");

  // a stalled result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_texture) &&
                                  $stable(out_last) && $stable(out_overflow)))
    else $error("stalled result changed");

endmodule

bind surface_filter_stable_sort_top sfss_checker u_sfss_checker (.*);

`default_nettype wire
